// ===== sv/dtnh_pkg.sv =====
// ----------------------------------------------------------------------------
// Dotted type name hash package
// Payload types, character codes and CRC-32C byte steps shared by the block.
// ----------------------------------------------------------------------------
package dtnh_pkg;

   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY   = 32'h82F6_3B78;
   localparam logic [11:0] LOW12_MASK = 12'hFFF;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_C    = 8'h63;
   localparam logic [7:0] CHAR_V    = 8'h76;
   localparam logic [7:0] CHAR_O    = 8'h6F;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] DECIMAL_BASE = 8'd10;

   localparam logic [2:0] TALLY_MAX = 3'd7;

   typedef struct packed {
      logic [7:0] name_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] type_hash;
      logic        hash_valid;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] ch);
      logic [31:0] r;
      r = crc ^ {24'd0, ch};
      for (int b = 0; b < 8; b++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

// ===== sv/dtnh_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one name character per request.
// ----------------------------------------------------------------------------
interface dtnh_req_if;
   import dtnh_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== sv/dtnh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one type hash per response.
// ----------------------------------------------------------------------------
interface dtnh_rsp_if;
   import dtnh_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== sv/dtnh_hash_core.sv =====
// ----------------------------------------------------------------------------
// Hash core
// Splits the name at its dots, runs the segment CRCs and the major version
// value, and forms the hash of the name whose final character is stepped.
// ----------------------------------------------------------------------------
module dtnh_hash_core
   import dtnh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    item,
   output rsp_type    result
);

   logic [2:0]  tally_ff, tally_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] second_ff, second_in;
   logic [31:0] tail_ff, tail_in;
   logic [31:0] last_dot_ff, last_dot_in;
   logic [31:0] prior_dot_ff, prior_dot_in;
   logic [7:0]  segment_ff, segment_in;
   logic        ended_ff, ended_in;
   logic [7:0]  major_ff, major_in;

   logic        is_dot;
   logic        is_digit;
   logic [31:0] root_final;
   logic [11:0] sub_hash;
   logic [11:0] name_hash;

   assign is_dot   = (item.name_char == CHAR_DOT);
   assign is_digit = (item.name_char >= CHAR_ZERO) && (item.name_char <= CHAR_NINE);

   always_comb begin
      tally_in     = tally_ff;
      root_in      = root_ff;
      second_in    = second_ff;
      tail_in      = tail_ff;
      last_dot_in  = last_dot_ff;
      prior_dot_in = prior_dot_ff;
      segment_in   = segment_ff;
      ended_in     = ended_ff;
      major_in     = major_ff;
      if (is_dot) begin
         if (tally_ff == 3'd0) begin
            root_in = crc_byte(crc_byte(root_ff, CHAR_C), CHAR_V);
         end
         if (tally_ff >= 3'd2) begin
            prior_dot_in = last_dot_ff;
            last_dot_in  = tail_ff;
            tail_in      = crc_byte(tail_ff, item.name_char);
         end
         major_in   = segment_ff;
         segment_in = 8'd0;
         ended_in   = 1'b0;
         if (tally_ff != TALLY_MAX) begin
            tally_in = tally_ff + 3'd1;
         end
      end else begin
         case (tally_ff)
            3'd0:    root_in   = crc_byte(root_ff, item.name_char);
            3'd1:    second_in = crc_byte(second_ff, item.name_char);
            default: tail_in   = crc_byte(tail_ff, item.name_char);
         endcase
         if (!ended_ff) begin
            if (is_digit) begin
               segment_in = 8'(segment_ff * DECIMAL_BASE) + (item.name_char - CHAR_ZERO);
            end else begin
               ended_in = 1'b1;
            end
         end
      end
   end

   // Root already holds "cv" once the first dot has gone by; finish with "o0".
   assign root_final = ~crc_byte(crc_byte(root_ff, CHAR_O), CHAR_ZERO);

   always_comb begin
      if (tally_in == 3'd3) begin
         sub_hash  = 12'd0;
         name_hash = ~second_ff[11:0] & LOW12_MASK;
      end else begin
         sub_hash  = ~second_ff[11:0] & LOW12_MASK;
         name_hash = ~prior_dot_in[11:0] & LOW12_MASK;
      end
      if (tally_in >= 3'd3) begin
         result.type_hash  = {root_final, sub_hash, name_hash, major_in};
         result.hash_valid = 1'b1;
      end else begin
         result.type_hash  = 64'd0;
         result.hash_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.is_last)) begin
         tally_ff     <= 3'd0;
         root_ff      <= CRC_PRESET;
         second_ff    <= CRC_PRESET;
         tail_ff      <= CRC_PRESET;
         last_dot_ff  <= CRC_PRESET;
         prior_dot_ff <= CRC_PRESET;
         segment_ff   <= 8'd0;
         ended_ff     <= 1'b0;
         major_ff     <= 8'd0;
      end else if (step) begin
         tally_ff     <= tally_in;
         root_ff      <= root_in;
         second_ff    <= second_in;
         tail_ff      <= tail_in;
         last_dot_ff  <= last_dot_in;
         prior_dot_ff <= prior_dot_in;
         segment_ff   <= segment_in;
         ended_ff     <= ended_in;
         major_ff     <= major_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      step && item.is_last |=> tally_ff == 3'd0 && root_ff == CRC_PRESET)
      else $error("state not restarted after final character");

   a_tally_saturates: assert property (@(posedge clock) disable iff (reset)
      tally_ff == TALLY_MAX && step && !item.is_last |=> tally_ff == TALLY_MAX)
      else $error("dot tally left saturation");

   a_root_frozen: assert property (@(posedge clock) disable iff (reset)
      tally_ff != 3'd0 && !(step && item.is_last) |=> $stable(root_ff))
      else $error("root crc changed after first dot");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      !result.hash_valid |-> result.type_hash == 64'd0)
      else $error("hash not zero for short name");

endmodule

// ===== sv/dotted_type_name_hash.sv =====
// ----------------------------------------------------------------------------
// Dotted type name hash
// Hashes a dotted type name, fed one character per request, to a 64-bit id.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one character per request, is_last set on the final
//   one. rsp_chan returns one response per name: type_hash and hash_valid,
//   the hash zero and hash_valid low when the name has fewer than three dots.
//   Both channels are valid/ready; a transfer happens when both are high.
//   A character is taken every cycle unless the input register stalls. The
//   final character is held in the input register, and the step through
//   the byte-wide CRC-32C logic lands the response in the output register.
//   While the response waits on rsp_chan, further characters of the next
//   name keep flowing; only a second final character stalls in the input
//   register until the response is taken, and req_chan.ready then drops.
//   Reset (synchronous, active high) empties both registers and presets the
//   CRCs; parsing state also returns to reset after every final character.
// ----------------------------------------------------------------------------
module dotted_type_name_hash
   import dtnh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   dtnh_req_if.sink   req_chan,
   dtnh_rsp_if.source rsp_chan
);

   logic    req_valid_ff;
   req_type req_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;

   logic    rsp_free;
   logic    advance;
   rsp_type result;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = req_valid_ff && (!req_item_ff.is_last || rsp_free);

   assign req_chan.ready   = !req_valid_ff || advance;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   dtnh_hash_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (req_item_ff),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && req_item_ff.is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            req_valid_ff <= req_chan.valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         req_item_ff <= req_chan.payload;
      end
      if (advance && req_item_ff.is_last) begin
         rsp_item_ff <= result;
      end
   end

endmodule

// ===== test/dotted_type_name_hash_test.sv =====
// ----------------------------------------------------------------------------
// Dotted type name hash testbench
// Streams dotted type names into the block one character per request and
// compares every returned hash against an in-bench CRC-32C parser of its own.
// A few hand-picked names come first, then random names (mostly well formed,
// some truncated, some noise) under four idling mixes, a long response
// hold-off that backs the block up, and paced names that drain fully.
// ----------------------------------------------------------------------------
module dotted_type_name_hash_test;
   import dtnh_pkg::*;

   localparam logic [7:0]  DOT_CODE        = 8'h2E;
   localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
   localparam logic [7:0]  DIGIT_NINE      = 8'h39;
   localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
   localparam logic [31:0] ROOT_SUFFIX     = "cvo0";
   localparam int          HOLD_LENGTH     = 250;
   localparam int          SETTLE_CYCLES   = 8;

   logic clock;
   logic reset;

   dtnh_req_if req_chan ();
   dtnh_rsp_if rsp_chan ();

   dotted_type_name_hash dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // parser state of the name in flight
   logic [2:0]  dots_seen;
   logic [31:0] root_acc;
   logic [31:0] second_acc;
   logic [31:0] tail_acc;
   logic [31:0] tail_at_last_dot;
   logic [31:0] tail_at_prior_dot;
   logic [7:0]  segment_value;
   logic        segment_ended;
   logic [7:0]  major_value;

   rsp_type     expected_hashes[$];
   logic [7:0]  name_text[$];

   int unsigned mismatch_count;
   int unsigned names_sent;
   int unsigned chars_sent;
   int unsigned hashes_checked;
   int unsigned full_hashes_seen;
   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned hold_requests;
   int unsigned hold_seen;
   int unsigned hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [31:0] crc32c_step(input logic [31:0] acc, input logic [7:0] ch);
      logic [31:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ ch[k];
         r  = r >> 1;
         if (fb) r = r ^ CASTAGNOLI_POLY;
      end
      return r;
   endfunction

   function automatic void clear_name_state();
      dots_seen         = '0;
      root_acc          = '1;
      second_acc        = '1;
      tail_acc          = '1;
      tail_at_last_dot  = '1;
      tail_at_prior_dot = '1;
      segment_value     = '0;
      segment_ended     = 1'b0;
      major_value       = '0;
   endfunction

   function automatic bit predict_type_hash(input logic [7:0] ch, input logic last,
                                            output rsp_type hash_out);
      logic [11:0] sub_part;
      logic [11:0] name_part;
      hash_out = '0;
      if (ch == DOT_CODE) begin
         if (dots_seen == 3'd0)
            for (int i = 3; i >= 0; i--) root_acc = crc32c_step(root_acc, ROOT_SUFFIX[i*8 +: 8]);
         if (dots_seen >= 3'd2) begin
            tail_at_prior_dot = tail_at_last_dot;
            tail_at_last_dot  = tail_acc;
            tail_acc          = crc32c_step(tail_acc, ch);
         end
         major_value   = segment_value;
         segment_value = '0;
         segment_ended = 1'b0;
         if (dots_seen != 3'd7) dots_seen = dots_seen + 3'd1;
      end else begin
         case (dots_seen)
            3'd0:    root_acc   = crc32c_step(root_acc, ch);
            3'd1:    second_acc = crc32c_step(second_acc, ch);
            default: tail_acc   = crc32c_step(tail_acc, ch);
         endcase
         if (!segment_ended) begin
            if (ch >= DIGIT_ZERO && ch <= DIGIT_NINE)
               segment_value = segment_value * 8'd10 + (ch - DIGIT_ZERO);
            else
               segment_ended = 1'b1;
         end
      end
      if (!last) return 1'b0;
      if (dots_seen >= 3'd3) begin
         if (dots_seen == 3'd3) begin
            sub_part  = '0;
            name_part = ~second_acc[11:0];
         end else begin
            sub_part  = ~second_acc[11:0];
            name_part = ~tail_at_prior_dot[11:0];
         end
         hash_out.type_hash  = {~root_acc, sub_part, name_part, major_value};
         hash_out.hash_valid = 1'b1;
      end
      clear_name_state();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = HOLD_LENGTH;
      end
      if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_hashes.size() == 0) begin
            report_mismatch($sformatf("response %h/%b with no hash expected",
                                      rsp_chan.payload.type_hash, rsp_chan.payload.hash_valid));
         end else begin
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (want.hash_valid) full_hashes_seen++;
            if (rsp_chan.payload.type_hash !== want.type_hash)
               report_mismatch($sformatf("type_hash %h, expected %h",
                                         rsp_chan.payload.type_hash, want.type_hash));
            if (rsp_chan.payload.hash_valid !== want.hash_valid)
               report_mismatch($sformatf("hash_valid %b, expected %b",
                                         rsp_chan.payload.hash_valid, want.hash_valid));
         end
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic last);
      rsp_type h;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.payload   <= '{name_char: ch, is_last: last};
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      chars_sent++;
      if (predict_type_hash(ch, last, h)) expected_hashes.insert(expected_hashes.size(), h);
   endtask

   task automatic send_name();
      for (int i = 0; i < name_text.size(); i++)
         send_char(name_text[i], i == name_text.size() - 1);
      names_sent++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void append_char(input logic [7:0] c);
      name_text.insert(name_text.size(), c);
   endfunction

   function automatic void load_text(input string s);
      name_text.delete();
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endfunction

   function automatic logic [7:0] pick_text_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0, 1, 2, 3: c = 8'(8'h61 + $urandom_range(25));
         4:          c = 8'(8'h41 + $urandom_range(25));
         5:          c = 8'(DIGIT_ZERO + $urandom_range(9));
         default: begin
            do c = 8'($urandom_range(255)); while (c == DOT_CODE);
         end
      endcase
      return c;
   endfunction

   function automatic void add_word(input int unsigned len);
      for (int i = 0; i < len; i++) append_char(pick_text_char());
   endfunction

   function automatic void add_digits(input int unsigned len);
      for (int i = 0; i < len; i++) append_char(8'(DIGIT_ZERO + $urandom_range(9)));
   endfunction

   function automatic void add_major();
      case ($urandom_range(15))
         0:       append_char("-");
         1:       append_char(" ");
         default: ;
      endcase
      add_digits($urandom_range(0, 4));
      if ($urandom_range(3) == 0) add_word($urandom_range(1, 3));
   endfunction

   function automatic void build_wellformed_name();
      int unsigned extra;
      name_text.delete();
      extra = $urandom_range(0, 3);
      add_word($urandom_range(0, 6));
      append_char(DOT_CODE);
      if (extra > 0) begin
         add_word($urandom_range(0, 5));
         append_char(DOT_CODE);
      end
      add_word($urandom_range(0, 6));
      for (int i = 1; i < extra; i++) begin
         append_char(DOT_CODE);
         add_word($urandom_range(0, 4));
      end
      append_char(DOT_CODE);
      add_major();
      append_char(DOT_CODE);
      add_digits($urandom_range(0, 3));
      if ($urandom_range(15) == 0) append_char(DOT_CODE);
   endfunction

   function automatic void build_random_name();
      int unsigned pick;
      int unsigned keep;
      int unsigned len;
      pick = $urandom_range(99);
      if (pick < 70) begin
         build_wellformed_name();
      end else if (pick < 85) begin
         build_wellformed_name();
         keep = $urandom_range(1, name_text.size());
         while (name_text.size() > keep) void'(name_text.pop_back());
      end else begin
         name_text.delete();
         len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            append_char(($urandom_range(4) == 0) ? DOT_CODE : 8'($urandom_range(255)));
      end
   endfunction

   task automatic test_directed_names();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      load_text("a.b.300.0");
      send_name();
      load_text("r.s.t.u.12x.");
      send_name();
      load_text("........");
      send_name();
      load_text("x");
      send_name();
      name_text = '{8'h00, 8'hFF};
      send_name();
      drain_responses();
   endtask

   task automatic test_random_names(input int unsigned budget);
      int unsigned target;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
            default: begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
         endcase
         target = chars_sent + budget / 4;
         while (chars_sent < target) begin
            build_random_name();
            send_name();
         end
      end
      drain_responses();
   endtask

   task automatic test_response_hold_off();
      int unsigned target;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_requests++;
      target = chars_sent + 150;
      while (chars_sent < target) begin
         build_wellformed_name();
         send_name();
      end
      drain_responses();
   endtask

   task automatic test_paced_names();
      sender_idle_pct    = 6;
      receiver_stall_pct = 81;
      for (int i = 0; i < 4; i++) begin
         build_wellformed_name();
         send_name();
         drain_responses();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.payload   = '0;
      rsp_chan.ready     = 1'b0;
      mismatch_count     = 0;
      names_sent         = 0;
      chars_sent         = 0;
      hashes_checked     = 0;
      full_hashes_seen   = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_requests      = 0;
      hold_seen          = 0;
      hold_left          = 0;
      clear_name_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_names();
      test_random_names(1500);
      test_response_hold_off();
      test_paced_names();

      $display("Covered %0d names in %0d characters: directed, four idling mixes,",
               names_sent, chars_sent);
      $display("a long response hold-off and drained pauses; %0d hashes checked, %0d valid.",
               hashes_checked, full_hashes_seen);
      if (mismatch_count == 0 && expected_hashes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/dtnh_pkg.sv
sv/dtnh_req_if.sv
sv/dtnh_rsp_if.sv
sv/dtnh_hash_core.sv
sv/dotted_type_name_hash.sv
test/dotted_type_name_hash_test.sv
